// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define SMAC_ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SMAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/smac_pkg.sv
// Shared types, constants and a helper function of the sliding-mode angle controller.
package smac_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 56;
	localparam int FIELD_W    = 27;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	localparam logic [30:0] RATE_GAIN_RST   = 31'd65536;
	localparam logic [30:0] ANGLE_GAIN_RST  = 31'd4096;
	localparam logic [25:0] RELAY_LEVEL_RST = 26'd65536000;
	localparam logic [30:0] INTEG_GAIN_RST  = 31'd655;
	localparam logic [16:0] FILTER_GAIN_RST = 17'd655;

	localparam logic signed [64:0] SAT_MAX = 65'sd2147483647;
	localparam logic signed [64:0] SAT_MIN = -65'sd2147483648;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RATE_GAIN   = 3'd0,
		REG_ANGLE_GAIN  = 3'd1,
		REG_RELAY_LEVEL = 3'd2,
		REG_INTEG_GAIN  = 3'd3,
		REG_FILTER_GAIN = 3'd4
	} smac_reg_t;

	typedef struct packed {
		logic [30:0] rate_gain;
		logic [30:0] angle_gain;
		logic [25:0] relay_level;
		logic [30:0] integ_gain;
		logic [16:0] filter_gain;
	} smac_cfg_t;

	// Operand selection of the shared multiplier.
	typedef enum logic [2:0] {
		MSEL_ANGLE,
		MSEL_RATE,
		MSEL_ANGLE_ERR,
		MSEL_RATE_ERR,
		MSEL_RELAY
	} smac_msel_t;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		smac_msel_t mul_sel;
		logic       upd_angle;
		logic       upd_rate;
		logic       upd_rate_err;
		logic       upd_relay;
		logic       upd_accum;
	} smac_cmd_t;

	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX) begin
			r = 32'sh7fffffff;
		end else if (v < SAT_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/sliding_mode_angle_controller_unit.sv
// Top level of the sliding-mode angle controller with stream ports and a register write port.
// One sample is taken per input transfer and yields one result transfer. A new sample is
// accepted only while the block is idle, once the previous one has left the sequence; the
// work is set by five products (two filter updates, the angle gain, the rate gain and the
// integrator step) run in turn on one shared 33 x 32 bit multiplier whose product is
// registered before use. A finished result waits in its own register, and the next sample
// is accepted meanwhile. Registers must be written by the user only while the block is
// idle; the block itself does not enforce this.
module sliding_mode_angle_controller_unit #(
	parameter int FRAC_BITS = smac_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// target_angle, meas_angle, meas_rate, accel_feedback
	input  logic [smac_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// drive, relay_out, two zero bits
	output logic [smac_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	input  logic                                 cfg_we,
	input  logic [smac_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [smac_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import smac_pkg::*;

	smac_cfg_t          cfg;
	smac_cmd_t          cmd;
	logic [FIELD_W-1:0] drive;
	logic [FIELD_W-1:0] relay_out;

	smac_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	smac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	smac_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg),
		.in_data   (s_axis_tdata),
		.drive     (drive),
		.relay_out (relay_out)
	);

	assign m_axis_tdata = {2'b00, relay_out, drive};

endmodule

// File: hw/rtl/smac_cfg_regs.sv
// Configuration register bank of the sliding-mode angle controller.
module smac_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [smac_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [smac_pkg::CFG_DATA_W-1:0]    cfg_data,
	output smac_pkg::smac_cfg_t                cfg
);
	import smac_pkg::*;

	smac_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_gain   <= RATE_GAIN_RST;
			cfg_q.angle_gain  <= ANGLE_GAIN_RST;
			cfg_q.relay_level <= RELAY_LEVEL_RST;
			cfg_q.integ_gain  <= INTEG_GAIN_RST;
			cfg_q.filter_gain <= FILTER_GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RATE_GAIN:   cfg_q.rate_gain   <= cfg_data[30:0];
				REG_ANGLE_GAIN:  cfg_q.angle_gain  <= cfg_data[30:0];
				REG_RELAY_LEVEL: cfg_q.relay_level <= cfg_data[25:0];
				REG_INTEG_GAIN:  cfg_q.integ_gain  <= cfg_data[30:0];
				REG_FILTER_GAIN: cfg_q.filter_gain <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/smac_ctrl.sv
// Sequencer of the controller: steps the datapath through one sample.
module smac_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output smac_pkg::smac_cmd_t  cmd
);
	import smac_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_ANGLE,
		ST_MUL_RATE,
		ST_MUL_ANGLE_ERR,
		ST_RATE_ERR,
		ST_MUL_RATE_ERR,
		ST_RELAY,
		ST_MUL_RELAY,
		ST_ACCUM
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// The result register may be reloaded once its previous content is gone.
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_ACCUM && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MUL_ANGLE;
					end
				end
				ST_MUL_ANGLE:     state_q <= ST_MUL_RATE;
				ST_MUL_RATE:      state_q <= ST_MUL_ANGLE_ERR;
				ST_MUL_ANGLE_ERR: state_q <= ST_RATE_ERR;
				ST_RATE_ERR:      state_q <= ST_MUL_RATE_ERR;
				ST_MUL_RATE_ERR:  state_q <= ST_RELAY;
				ST_RELAY:         state_q <= ST_MUL_RELAY;
				ST_MUL_RELAY:     state_q <= ST_ACCUM;
				ST_ACCUM: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = MSEL_ANGLE;
		case (state_q)
			ST_IDLE:  cmd.load = in_valid;
			ST_MUL_ANGLE: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_ANGLE;
			end
			ST_MUL_RATE: begin
				cmd.upd_angle = 1'b1;
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = MSEL_RATE;
			end
			ST_MUL_ANGLE_ERR: begin
				cmd.upd_rate = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MSEL_ANGLE_ERR;
			end
			ST_RATE_ERR:  cmd.upd_rate_err = 1'b1;
			ST_MUL_RATE_ERR: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_RATE_ERR;
			end
			ST_RELAY:     cmd.upd_relay = 1'b1;
			ST_MUL_RELAY: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_RELAY;
			end
			ST_ACCUM:     cmd.upd_accum = out_free;
			default: ;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: hw/rtl/smac_datapath.sv
// Datapath of the controller: filters, error chain, relay and integrator on one multiplier.
module smac_datapath #(
	parameter int FRAC_BITS = smac_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  smac_pkg::smac_cmd_t                    cmd,
	input  smac_pkg::smac_cfg_t                    cfg,
	input  logic [smac_pkg::IN_DATA_W-1:0]         in_data,
	output logic [smac_pkg::FIELD_W-1:0]           drive,
	output logic [smac_pkg::FIELD_W-1:0]           relay_out
);
	import smac_pkg::*;

	localparam logic signed [63:0] LimWide  = 64'sd1000 <<< FRAC_BITS;
	localparam logic signed [31:0] DriveLim =
		(LimWide > 64'sd2147483647) ? 32'sh7fffffff : LimWide[31:0];
	localparam logic [31:0] GainOne = 32'd1 << FRAC_BITS;

	logic signed [31:0] tgt_q, ang_q, rate_q, accfb_q;
	logic signed [31:0] filt_angle_q, filt_rate_q, prev_relay_q, integ_q;
	logic signed [31:0] rate_err_q;
	logic signed [64:0] prod_q;
	logic [FIELD_W-1:0] drive_q, relay_out_q;

	logic [31:0]        filt_gain;
	logic signed [32:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [64:0] prod_sh;
	logic signed [31:0] angle_err;
	logic signed [31:0] scaled;
	logic signed [31:0] rate_err;
	logic signed [32:0] relay_diff;
	logic signed [31:0] level;
	logic signed [31:0] relay_raw;
	logic signed [31:0] relay_val;
	logic signed [65:0] integ_sum;
	logic signed [31:0] integ_next;

	// A gain above one is taken as one.
	assign filt_gain = ({15'd0, cfg.filter_gain} > GainOne) ? GainOne : {15'd0, cfg.filter_gain};

	assign prod_sh   = prod_q >>> FRAC_BITS;
	assign scaled    = sat32(prod_sh);
	assign angle_err = sat32(65'(33'(tgt_q) - 33'(filt_angle_q)));
	assign rate_err  = sat32(65'(33'(scaled) - 33'(filt_rate_q)));

	always_comb begin
		mul_a = 33'(ang_q) - 33'(filt_angle_q);
		mul_b = $signed(filt_gain);
		case (cmd.mul_sel)
			MSEL_ANGLE: begin
				mul_a = 33'(ang_q) - 33'(filt_angle_q);
				mul_b = $signed(filt_gain);
			end
			MSEL_RATE: begin
				mul_a = 33'(rate_q) - 33'(filt_rate_q);
				mul_b = $signed(filt_gain);
			end
			MSEL_ANGLE_ERR: begin
				mul_a = 33'(angle_err);
				mul_b = $signed({1'b0, cfg.angle_gain});
			end
			MSEL_RATE_ERR: begin
				mul_a = 33'(rate_err_q);
				mul_b = $signed({1'b0, cfg.rate_gain});
			end
			MSEL_RELAY: begin
				mul_a = 33'(prev_relay_q);
				mul_b = $signed({1'b0, cfg.integ_gain});
			end
			default: ;
		endcase
	end

	// Relay: sign of the scaled rate error less the feedback, blanked on a reversal.
	assign relay_diff = 33'(scaled) - 33'(accfb_q);
	assign level = ($signed({6'd0, cfg.relay_level}) > DriveLim) ?
		DriveLim : $signed({6'd0, cfg.relay_level});
	assign relay_raw = (relay_diff > 33'sd0) ? level : -level;
	assign relay_val = ((relay_raw > 32'sd0 && prev_relay_q < 32'sd0) ||
		(relay_raw < 32'sd0 && prev_relay_q > 32'sd0)) ? 32'sd0 : relay_raw;

	assign integ_sum = 66'(integ_q) + 66'(prod_sh);
	always_comb begin
		if (integ_sum > 66'(DriveLim)) begin
			integ_next = DriveLim;
		end else if (integ_sum < -66'(DriveLim)) begin
			integ_next = -DriveLim;
		end else begin
			integ_next = integ_sum[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_angle_q <= '0;
			filt_rate_q  <= '0;
			prev_relay_q <= '0;
			integ_q      <= '0;
		end else begin
			// The filter outputs stay between old value and sample, so 32 bits hold them.
			if (cmd.upd_angle) begin
				filt_angle_q <= filt_angle_q + prod_sh[31:0];
			end
			if (cmd.upd_rate) begin
				filt_rate_q <= filt_rate_q + prod_sh[31:0];
			end
			if (cmd.upd_relay) begin
				prev_relay_q <= relay_val;
			end
			if (cmd.upd_accum) begin
				integ_q <= integ_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tgt_q   <= in_data[31:0];
			ang_q   <= in_data[63:32];
			rate_q  <= in_data[95:64];
			accfb_q <= in_data[127:96];
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.upd_rate_err) begin
			rate_err_q <= rate_err;
		end
		if (cmd.upd_accum) begin
			drive_q     <= integ_next[FIELD_W-1:0];
			relay_out_q <= prev_relay_q[FIELD_W-1:0];
		end
	end

	assign drive     = drive_q;
	assign relay_out = relay_out_q;

endmodule

// File: hw/rtl/smac_checker.sv
// Port-level checks of the sliding-mode angle controller, bound to its top level.
`include "assert_macros.svh"

module smac_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	input  logic                                 s_axis_tready,
	input  logic [smac_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	input  logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	input  logic [smac_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	input  logic                                 cfg_we,
	input  logic [smac_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [smac_pkg::CFG_DATA_W-1:0]      cfg_data
);
	logic unused_ok;
	assign unused_ok = ^{s_axis_tdata, m_axis_tdata, cfg_we, cfg_index, cfg_data};

	// A pending result is not withdrawn before it is taken.
	`SMAC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped before transfer")

	// After an input transfer the block is busy and no result appears at once.
	`SMAC_ASSERT_NEXT(a_busy_after_in, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready && !$rose(m_axis_tvalid), "input side not busy after transfer")

	// A new result only follows a cycle in which a sample was being worked on.
	`SMAC_ASSERT_PROP(a_result_from_work, clk, arst_n, $rose(m_axis_tvalid) |-> !$past(s_axis_tready), "result appeared without a sample in work")

endmodule

bind sliding_mode_angle_controller_unit smac_checker u_smac_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_we        (cfg_we),
	.cfg_index     (cfg_index),
	.cfg_data      (cfg_data)
);
